// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL files. Each macro expects signals named
// clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ltm_pkg.sv -----
package ltm_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 64;
   localparam int TIME_WIDTH_DEFAULT    = 32;

   // Peaks and full-scale registers are always 64 bits wide.
   localparam int PEAK_WIDTH     = 64;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int SHARE_WIDTH = 7;
   localparam logic [SHARE_WIDTH-1:0] SHARE_FULL = 7'd100;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUTO_PEAK      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IN_FULL_SCALE  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_FULL_SCALE = 2'd2;

   // Control from the top level to one direction unit.
   typedef struct packed {
      logic                  start;
      logic                  auto_peak;
      logic                  peak_load;
      logic [PEAK_WIDTH-1:0] peak_value;
   } ltm_ctl_type;

   // Status from one direction unit back to the top level.
   typedef struct packed {
      logic                   busy;
      logic [SHARE_WIDTH-1:0] share;
   } ltm_stat_type;

endpackage

// ----- design/ltm_dir.sv -----
`include "assert_macros.svh"

// One traffic direction: counter delta, bit-serial division by the elapsed
// time, peak tracking and a bit-serial percentage of the peak.
module ltm_dir #(
   parameter int CNT_W = ltm_pkg::COUNTER_WIDTH_DEFAULT,
   parameter int TIM_W = ltm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ltm_pkg::ltm_ctl_type             ctl,
   input  logic [CNT_W-1:0]                 total,
   input  logic [TIM_W-1:0]                 elapsed,
   output ltm_pkg::ltm_stat_type            stat,
   output logic [CNT_W-1:0]                 rate,
   output logic [ltm_pkg::PEAK_WIDTH-1:0]   peak
);
   import ltm_pkg::*;

   localparam int NUM_W  = CNT_W + SHARE_WIDTH;
   localparam int STEP_W = $clog2(NUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PEAK,
      ST_CHECK,
      ST_SHARE
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        prev_ff;
   logic [CNT_W-1:0]        rate_ff;
   logic [PEAK_WIDTH-1:0]   peak_ff;
   logic [SHARE_WIDTH-1:0]  share_ff;
   logic [CNT_W-1:0]        quo_ff;
   logic [TIM_W-1:0]        divisor_ff;
   logic [TIM_W-1:0]        rem_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [PEAK_WIDTH-1:0]   prem_ff;
   logic [STEP_W-1:0]       step_ff;

   logic [TIM_W:0]          div_trial;
   logic                    div_fit;
   logic [TIM_W:0]          div_rem;
   logic [CNT_W-1:0]        quo_in;
   logic [PEAK_WIDTH:0]     share_trial;
   logic                    share_fit;
   logic [PEAK_WIDTH:0]     share_rem;
   logic [NUM_W-1:0]        num_in;
   logic [PEAK_WIDTH-1:0]   quo_ext;
   logic [PEAK_WIDTH-1:0]   rate_ext;
   logic [NUM_W-1:0]        rate_wide;
   logic [NUM_W-1:0]        rate_x100;

   // Restoring division of the counter delta by the elapsed seconds,
   // one quotient bit per cycle.
   assign div_trial = {rem_ff, quo_ff[CNT_W-1]};
   assign div_fit   = div_trial >= {1'b0, divisor_ff};
   assign div_rem   = div_fit ? (div_trial - {1'b0, divisor_ff}) : div_trial;
   assign quo_in    = {quo_ff[CNT_W-2:0], div_fit};

   // Restoring division of 100 * rate by the peak, one bit per cycle.
   assign share_trial = {prem_ff, num_ff[NUM_W-1]};
   assign share_fit   = share_trial >= {1'b0, peak_ff};
   assign share_rem   = share_fit ? (share_trial - {1'b0, peak_ff}) : share_trial;
   assign num_in      = {num_ff[NUM_W-2:0], share_fit};

   assign quo_ext   = PEAK_WIDTH'(quo_ff);
   assign rate_ext  = PEAK_WIDTH'(rate_ff);
   assign rate_wide = NUM_W'(rate_ff);
   assign rate_x100 = (rate_wide << 6) + (rate_wide << 5) + (rate_wide << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         rate_ff  <= '0;
         peak_ff  <= '0;
         share_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (ctl.peak_load) begin
                  peak_ff <= ctl.peak_value;
               end
               if (ctl.start) begin
                  prev_ff <= total;
                  // The first nonzero total is only recorded.
                  if (prev_ff != '0) begin
                     quo_ff     <= total - prev_ff;
                     divisor_ff <= elapsed;
                     rem_ff     <= '0;
                     step_ff    <= STEP_W'(CNT_W - 1);
                     state_ff   <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               quo_ff  <= quo_in;
               rem_ff  <= div_rem[TIM_W-1:0];
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_PEAK;
               end
            end
            ST_PEAK: begin
               rate_ff <= quo_ff;
               if (ctl.auto_peak && (quo_ext > peak_ff)) begin
                  peak_ff <= quo_ext;
               end
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               priority if (peak_ff == '0) begin
                  share_ff <= '0;
                  state_ff <= ST_IDLE;
               end else if (rate_ext >= peak_ff) begin
                  share_ff <= SHARE_FULL;
                  state_ff <= ST_IDLE;
               end else begin
                  num_ff   <= rate_x100;
                  prem_ff  <= '0;
                  step_ff  <= STEP_W'(NUM_W - 1);
                  state_ff <= ST_SHARE;
               end
            end
            ST_SHARE: begin
               num_ff  <= num_in;
               prem_ff <= share_rem[PEAK_WIDTH-1:0];
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  share_ff <= num_in[SHARE_WIDTH-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign stat.busy  = (state_ff != ST_IDLE);
   assign stat.share = share_ff;
   assign rate       = rate_ff;
   assign peak       = peak_ff;

   `LTM_ASSERT_IMP(a_div_rem_below_divisor, (state_ff == ST_DIV) && (divisor_ff != '0), rem_ff < divisor_ff, "division remainder reached the divisor")
   `LTM_ASSERT_IMP(a_share_rem_below_peak, state_ff == ST_SHARE, prem_ff < peak_ff, "share remainder reached the peak")
   `LTM_ASSERT_NEXT(a_share_below_full, (state_ff == ST_SHARE) && (step_ff == '0), share_ff < SHARE_FULL, "computed share not below full scale")

endmodule

// ----- design/link_throughput_meter_unit.sv -----
`include "assert_macros.svh"

// Link throughput meter. Each request transaction carries a sample time in
// whole seconds and the cumulative received and sent byte counters; each one
// produces exactly one response transaction with the updated flag, the
// current rate, percentage of peak and peak for both directions. A sample
// that is not at least one second newer than the last recorded time changes
// nothing and answers with updated low; the very first sample only records
// the time, and the first nonzero counter of each direction is only stored.
// Both directions are computed in parallel by bit-serial restoring dividers,
// one quotient bit per cycle for the division by the elapsed time and, when
// the rate is below a nonzero peak, COUNTER_WIDTH + 7 bits for the percentage
// division; a non-updating sample goes straight to the response. The block
// takes one sample at a time, and a new request transaction may be accepted
// while the previous response still waits on the response channel. Writing
// in_full_scale or out_full_scale also loads that direction's peak, but only
// while that unit is idle; the user must write configuration only while no
// transaction is in flight, which the block itself does not enforce.
module link_throughput_meter_unit #(
   parameter int COUNTER_WIDTH = ltm_pkg::COUNTER_WIDTH_DEFAULT,
   parameter int TIME_WIDTH    = ltm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [TIME_WIDTH-1:0]                req_now_seconds,
   input  logic [COUNTER_WIDTH-1:0]             req_total_received,
   input  logic [COUNTER_WIDTH-1:0]             req_total_sent,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_updated,
   output logic [COUNTER_WIDTH-1:0]             rsp_receive_rate,
   output logic [ltm_pkg::SHARE_WIDTH-1:0]      rsp_receive_percent,
   output logic [ltm_pkg::PEAK_WIDTH-1:0]       rsp_receive_peak,
   output logic [COUNTER_WIDTH-1:0]             rsp_send_rate,
   output logic [ltm_pkg::SHARE_WIDTH-1:0]      rsp_send_percent,
   output logic [ltm_pkg::PEAK_WIDTH-1:0]       rsp_send_peak,

   input  logic                                 csr_we,
   input  logic [ltm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ltm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import ltm_pkg::*;

   // IDLE takes a request, RUN waits for both direction units, PUSH hands the
   // result to the response register as soon as that register is free.
   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_PUSH
   } state_type;

   state_type                 state_ff;
   logic [TIME_WIDTH-1:0]     last_ff;
   logic                      auto_peak_ff;
   logic                      upd_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_updated_ff;
   logic [COUNTER_WIDTH-1:0]  rsp_rx_rate_ff;
   logic [SHARE_WIDTH-1:0]    rsp_rx_share_ff;
   logic [PEAK_WIDTH-1:0]     rsp_rx_peak_ff;
   logic [COUNTER_WIDTH-1:0]  rsp_tx_rate_ff;
   logic [SHARE_WIDTH-1:0]    rsp_tx_share_ff;
   logic [PEAK_WIDTH-1:0]     rsp_tx_peak_ff;

   logic                      accept;
   logic [TIME_WIDTH-1:0]     last_eff;
   logic                      upd_now;
   logic [TIME_WIDTH-1:0]     elapsed_now;

   ltm_ctl_type               rx_ctl;
   ltm_ctl_type               tx_ctl;
   ltm_stat_type              rx_stat;
   ltm_stat_type              tx_stat;
   logic [COUNTER_WIDTH-1:0]  rx_rate;
   logic [COUNTER_WIDTH-1:0]  tx_rate;
   logic [PEAK_WIDTH-1:0]     rx_peak;
   logic [PEAK_WIDTH-1:0]     tx_peak;

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;

   // A stored time of zero means no sample has been seen yet; the incoming
   // time then stands in for it, which makes the elapsed time zero.
   assign last_eff    = (last_ff == '0) ? req_now_seconds : last_ff;
   assign upd_now     = (req_now_seconds > last_eff);
   assign elapsed_now = req_now_seconds - last_eff;

   assign rx_ctl.start      = accept && upd_now;
   assign rx_ctl.auto_peak  = auto_peak_ff;
   assign rx_ctl.peak_load  = csr_we && (csr_index == CSR_IN_FULL_SCALE);
   assign rx_ctl.peak_value = csr_wdata;

   assign tx_ctl.start      = accept && upd_now;
   assign tx_ctl.auto_peak  = auto_peak_ff;
   assign tx_ctl.peak_load  = csr_we && (csr_index == CSR_OUT_FULL_SCALE);
   assign tx_ctl.peak_value = csr_wdata;

   ltm_dir #(
      .CNT_W (COUNTER_WIDTH),
      .TIM_W (TIME_WIDTH)
   ) u_rx (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rx_ctl),
      .total   (req_total_received),
      .elapsed (elapsed_now),
      .stat    (rx_stat),
      .rate    (rx_rate),
      .peak    (rx_peak)
   );

   ltm_dir #(
      .CNT_W (COUNTER_WIDTH),
      .TIM_W (TIME_WIDTH)
   ) u_tx (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tx_ctl),
      .total   (req_total_sent),
      .elapsed (elapsed_now),
      .stat    (tx_stat),
      .rate    (tx_rate),
      .peak    (tx_peak)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         last_ff      <= '0;
         auto_peak_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_AUTO_PEAK)) begin
            auto_peak_ff <= csr_wdata[0];
         end

         // The response transaction completes. In the push state the register
         // is refilled below in the same cycle instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != T_PUSH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  if ((last_ff == '0) || upd_now) begin
                     last_ff <= req_now_seconds;
                  end
                  upd_ff   <= upd_now;
                  state_ff <= upd_now ? T_RUN : T_PUSH;
               end
            end
            T_RUN: begin
               if (!rx_stat.busy && !tx_stat.busy) begin
                  state_ff <= T_PUSH;
               end
            end
            T_PUSH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_updated_ff  <= upd_ff;
                  rsp_rx_rate_ff  <= rx_rate;
                  rsp_rx_share_ff <= rx_stat.share;
                  rsp_rx_peak_ff  <= rx_peak;
                  rsp_tx_rate_ff  <= tx_rate;
                  rsp_tx_share_ff <= tx_stat.share;
                  rsp_tx_peak_ff  <= tx_peak;
                  state_ff        <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_updated         = rsp_updated_ff;
   assign rsp_receive_rate    = rsp_rx_rate_ff;
   assign rsp_receive_percent = rsp_rx_share_ff;
   assign rsp_receive_peak    = rsp_rx_peak_ff;
   assign rsp_send_rate       = rsp_tx_rate_ff;
   assign rsp_send_percent    = rsp_tx_share_ff;
   assign rsp_send_peak       = rsp_tx_peak_ff;

   `LTM_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != T_IDLE, "accepted transaction left the controller idle")
   `LTM_ASSERT_IMP(a_push_units_idle, state_ff == T_PUSH, !rx_stat.busy && !tx_stat.busy, "result pushed while a direction unit is busy")
   `LTM_ASSERT_IMP(a_percent_in_range, rsp_valid_ff, (rsp_rx_share_ff <= SHARE_FULL) && (rsp_tx_share_ff <= SHARE_FULL), "response percentage above full scale")

endmodule
